// ----- src/gcdlcm_pkg.sv -----
package gcdlcm_pkg;

    localparam int OPERAND_BITS_DEF = 31;

    // results above 2**LIMIT_BITS - 1 are flagged as large
    localparam int LIMIT_BITS = 31;

    typedef logic [1:0] t_status;

    localparam t_status STAT_OK   = 2'd0;
    localparam t_status STAT_ZERO = 2'd1;
    localparam t_status STAT_BIG  = 2'd2;

endpackage

// ----- src/gcdlcm_div.sv -----
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module gcdlcm_div #(
    parameter int W = gcdlcm_pkg::OPERAND_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;
    logic [W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = !diff[W];
        n_rem = fits ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_rem <= '0;
                r_quo <= i_dividend;
                r_dvs <= i_divisor;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- src/gcd_lcm_unit_top.sv -----
// One shared bit-serial divider runs every remainder step of Euclid's loop and the quotient.
// Both operands zero: o_done rises in the cycle after accept.
// Throughput: one item at a time; busy stays high until the result strobe.
// The result is shown for one cycle on o_done; the receiver cannot stall.
// Reset (synchronous, active low) aborts any item in flight and clears busy.
module gcd_lcm_unit_top #(
    parameter int OPERAND_BITS = gcdlcm_pkg::OPERAND_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OPERAND_BITS-1:0]   i_operand_a,
    input  logic [OPERAND_BITS-1:0]   i_operand_b,
    output logic                      o_done,
    output logic [OPERAND_BITS-1:0]   o_divisor,
    output logic [((2*OPERAND_BITS >= 64) ? 64 : 2*OPERAND_BITS)-1:0] o_multiple,
    output gcdlcm_pkg::t_status       o_status
);

    localparam int N  = OPERAND_BITS;
    localparam int MW = (2 * N >= 64) ? 64 : 2 * N;
    localparam int CW = $clog2(N);

    typedef enum logic [2:0] {
        S_IDLE,
        S_XMOD,
        S_YMOD,
        S_QDIV,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state;

    logic [N-1:0]   r_x;
    logic [N-1:0]   r_y;
    logic [N-1:0]   r_a;
    logic [N-1:0]   r_b;
    logic [N-1:0]   r_g;
    logic [2*N-1:0] r_prod;
    logic [CW-1:0]  r_cnt;

    logic           r_div_go;
    logic [N-1:0]   r_dvd;
    logic [N-1:0]   r_dvs;

    logic                r_done;
    logic [N-1:0]        r_divisor;
    logic [MW-1:0]       r_multiple;
    gcdlcm_pkg::t_status r_status;

    logic         div_done;
    logic [N-1:0] div_quo;
    logic [N-1:0] div_rem;

    logic [N:0] mul_sum;
    logic       prod_big;
    logic       accept;

    gcdlcm_div #(
        .W (N)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (r_div_go),
        .i_dividend  (r_dvd),
        .i_divisor   (r_dvs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign accept = start && !busy;

    // shift-add multiply, LSB of the multiplier first, product shifts right
    always_comb begin
        mul_sum  = {1'b0, r_prod[2*N-1:N]} + (r_prod[0] ? {1'b0, r_b} : '0);
        prod_big = |(r_prod >> gcdlcm_pkg::LIMIT_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_div_go <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_div_go <= 1'b0;
            r_done   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a <= i_operand_a;
                        r_b <= i_operand_b;
                        r_x <= i_operand_a;
                        r_y <= i_operand_b;
                        if (i_operand_b == '0) begin
                            r_g <= i_operand_a;
                            if (i_operand_a == '0) begin
                                r_done     <= 1'b1;
                                r_divisor  <= '0;
                                r_multiple <= '0;
                                r_status   <= gcdlcm_pkg::STAT_ZERO;
                            end else begin
                                r_div_go <= 1'b1;
                                r_dvd    <= i_operand_a;
                                r_dvs    <= i_operand_a;
                                r_state  <= S_QDIV;
                            end
                        end else begin
                            r_div_go <= 1'b1;
                            r_dvd    <= i_operand_a;
                            r_dvs    <= i_operand_b;
                            r_state  <= S_XMOD;
                        end
                    end
                end
                S_XMOD: begin
                    if (div_done) begin
                        r_div_go <= 1'b1;
                        if (div_rem == '0) begin
                            r_g     <= r_y;
                            r_dvd   <= r_a;
                            r_dvs   <= r_y;
                            r_state <= S_QDIV;
                        end else begin
                            r_x     <= div_rem;
                            r_dvd   <= r_y;
                            r_dvs   <= div_rem;
                            r_state <= S_YMOD;
                        end
                    end
                end
                S_YMOD: begin
                    if (div_done) begin
                        r_div_go <= 1'b1;
                        if (div_rem == '0) begin
                            r_g     <= r_x;
                            r_dvd   <= r_a;
                            r_dvs   <= r_x;
                            r_state <= S_QDIV;
                        end else begin
                            r_y     <= div_rem;
                            r_dvd   <= r_x;
                            r_dvs   <= div_rem;
                            r_state <= S_XMOD;
                        end
                    end
                end
                S_QDIV: begin
                    if (div_done) begin
                        r_prod  <= {{N{1'b0}}, div_quo};
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= {mul_sum, r_prod[N-1:1]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(N - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_done     <= 1'b1;
                    r_divisor  <= r_g;
                    r_multiple <= r_prod[MW-1:0];
                    r_status   <= prod_big ? gcdlcm_pkg::STAT_BIG : gcdlcm_pkg::STAT_OK;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_divisor  = r_divisor;
    assign o_multiple = r_multiple;
    assign o_status   = r_status;

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_OUT) ||
                   ($past(accept) && $past(i_operand_a) == '0 && $past(i_operand_b) == '0))
        else $error("result strobe without a finished item");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == gcdlcm_pkg::STAT_ZERO |-> o_divisor == '0 && o_multiple == '0)
        else $error("both-zero item gave nonzero result");

    a_nonzero_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != gcdlcm_pkg::STAT_ZERO |-> o_divisor != '0)
        else $error("zero divisor on a nonzero item");

    a_busy_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

endmodule

// ----- verif/gcd_lcm_unit_top_tb.sv -----
module gcd_lcm_unit_top_tb;

    import gcdlcm_pkg::*;

    localparam int OB = OPERAND_BITS_DEF;
    localparam int MB = (2*OB >= 64) ? 64 : 2*OB;
    localparam logic [OB-1:0] OP_MAX = {OB{1'b1}};
    localparam longint unsigned BIG_LIMIT = (64'd1 << LIMIT_BITS) - 1;
    localparam int NUM_DIRECTED = 22;
    localparam int RANDOM_ITEMS = 1730;
    // covers the worst case: about 46 divider passes plus the multiply
    localparam int DRAIN_CYCLES = 2000;
    localparam longint unsigned TIMEOUT = 64'd1750 * 64'd1800 * 64'd10 * 64'd4;

    typedef struct packed {
        logic [OB-1:0] divisor;
        logic [MB-1:0] multiple;
        t_status       status;
    } t_lcm_result;

    typedef struct packed {
        logic [OB-1:0] op_a;
        logic [OB-1:0] op_b;
        logic          known;
        t_lcm_result   want;
    } t_directed_row;

    typedef enum int {
        MIX_FULL, MIX_SHARED, MIX_TINY, MIX_FIB, MIX_ZERO,
        MIX_EQUAL, MIX_DIVIDES, MIX_NEAR_LIMIT, MIX_SHIFTED
    } t_operand_mix;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [OB-1:0] i_operand_a;
    logic [OB-1:0] i_operand_b;
    logic          o_done;
    logic [OB-1:0] o_divisor;
    logic [MB-1:0] o_multiple;
    t_status       o_status;

    t_lcm_result pending_results[$];
    int          fail_count = 0;

    // known rows carry a typed result; the rest go through gcd_lcm_of
    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{31'd0,          31'd0,          1'b1, '{31'd0, 62'd0, STAT_ZERO}},
        '{31'd0,          31'd5,          1'b1, '{31'd5, 62'd0, STAT_OK}},
        '{31'd7,          31'd0,          1'b1, '{31'd7, 62'd0, STAT_OK}},
        '{OP_MAX,         31'd0,          1'b1, '{OP_MAX, 62'd0, STAT_OK}},
        '{31'd0,          OP_MAX,         1'b1, '{OP_MAX, 62'd0, STAT_OK}},
        '{31'd1,          31'd0,          1'b1, '{31'd1, 62'd0, STAT_OK}},
        '{31'd1,          31'd1,          1'b1, '{31'd1, 62'd1, STAT_OK}},
        '{OP_MAX,         OP_MAX,         1'b1, '{OP_MAX, 62'(OP_MAX), STAT_OK}},
        '{OP_MAX,         31'd1,          1'b1, '{31'd1, 62'(OP_MAX), STAT_OK}},
        '{31'd1,          OP_MAX,         1'b1, '{31'd1, 62'(OP_MAX), STAT_OK}},
        '{OP_MAX,         OP_MAX - 31'd1, 1'b0, '0},
        '{31'd2147483646, 31'd2,          1'b1, '{31'd2, 62'd2147483646, STAT_OK}},
        '{31'd12,         31'd18,         1'b1, '{31'd6, 62'd36, STAT_OK}},
        '{31'd65536,      31'd32768,      1'b1, '{31'd32768, 62'd65536, STAT_OK}},
        '{31'd65536,      31'd65537,      1'b1, '{31'd1, 62'd4295032832, STAT_BIG}},
        '{31'd1836311903, 31'd1134903170, 1'b0, '0},
        '{31'd1134903170, 31'd1836311903, 1'b0, '0},
        '{31'd46341,      31'd46340,      1'b0, '0},
        '{31'd46341,      31'd46342,      1'b0, '0},
        '{OP_MAX,         31'd1073741824, 1'b0, '0},
        '{31'd1073741824, 31'd1073741824, 1'b1, '{31'd1073741824, 62'd1073741824, STAT_OK}},
        '{OP_MAX,         31'd2,          1'b1, '{31'd1, 62'd4294967294, STAT_BIG}}
    };

    gcd_lcm_unit_top #(
        .OPERAND_BITS(OB)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_done      (o_done),
        .o_divisor   (o_divisor),
        .o_multiple  (o_multiple),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT);
        $display("simulation failed");
        $finish;
    end

    function automatic t_lcm_result gcd_lcm_of(input logic [OB-1:0] a, input logic [OB-1:0] b);
        longint unsigned x, y, g, prod;
        t_lcm_result r;
        x = 64'(a);
        y = 64'(b);
        // alternate remainders until one side clears; the other is the divisor
        while (x != 0 && y != 0) begin
            x = x % y;
            if (x != 0) y = y % x;
        end
        g = x + y;
        r.divisor = g[OB-1:0];
        if (g == 0) begin
            r.multiple = '0;
            r.status   = STAT_ZERO;
        end else begin
            prod       = (64'(a) / g) * 64'(b);
            r.multiple = prod[MB-1:0];
            r.status   = (prod > BIG_LIMIT) ? STAT_BIG : STAT_OK;
        end
        return r;
    endfunction

    task automatic random_operands(output logic [OB-1:0] a, output logic [OB-1:0] b);
        t_operand_mix mix;
        int unsigned pick;
        longint unsigned f0, f1, t, g;
        pick = $urandom_range(0, 9);
        mix  = (pick > MIX_SHIFTED) ? MIX_FULL : t_operand_mix'(pick);
        a = OB'($urandom());
        b = OB'($urandom());
        case (mix)
            MIX_SHARED: begin
                g = 64'($urandom_range(1, 65535));
                a = OB'(g * $urandom_range(1, 32767));
                b = OB'(g * $urandom_range(1, 32767));
            end
            MIX_TINY: begin
                a = OB'($urandom_range(0, 20));
                b = OB'($urandom_range(0, 20));
            end
            MIX_FIB: begin
                // consecutive Fibonacci numbers take the most Euclid steps
                f0 = 64'd0;
                f1 = 64'd1;
                repeat ($urandom_range(1, 45)) begin
                    t  = f0 + f1;
                    f0 = f1;
                    f1 = t;
                end
                a = OB'(f1);
                b = OB'(f0);
                if ($urandom_range(0, 1)) begin
                    a = OB'(f0);
                    b = OB'(f1);
                end
            end
            MIX_ZERO: begin
                if ($urandom_range(0, 1)) a = '0;
                else b = '0;
            end
            MIX_EQUAL: b = a;
            MIX_DIVIDES: begin
                b = OB'($urandom_range(1, 65535));
                a = OB'(64'(b) * $urandom_range(0, 32767));
                if ($urandom_range(0, 1)) begin
                    t = 64'(a);
                    a = b;
                    b = OB'(t);
                end
            end
            MIX_NEAR_LIMIT: begin
                a = OB'($urandom_range(30000, 70000));
                b = OB'($urandom_range(30000, 70000));
            end
            MIX_SHIFTED: begin
                a = a >> $urandom_range(0, OB-1);
                b = b >> $urandom_range(0, OB-1);
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [OB-1:0] a, input logic [OB-1:0] b,
                             input int gap, input t_lcm_result want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(want);
    endtask

    // called right after send_item returns, so start drops once here
    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic int idle_gap(input bit quiet);
        if (quiet || $urandom_range(0, 99) >= 24) return 0;
        return $urandom_range(1, 8);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_lcm_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result: divisor %0d multiple %0d status %0d",
                                       o_divisor, o_multiple, o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_divisor !== want.divisor || o_multiple !== want.multiple ||
                    o_status !== want.status)
                    note_failure($sformatf(
                        "mismatch: divisor %0d/%0d multiple %0d/%0d status %0d/%0d (exp/act)",
                        want.divisor, o_divisor, want.multiple, o_multiple,
                        want.status, o_status));
            end
        end
    end

    initial begin
        logic [OB-1:0] a, b;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operand_a <= '0;
        i_operand_b <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].op_a, directed_rows[k].op_b, idle_gap(1'b0),
                      directed_rows[k].known ? directed_rows[k].want
                                             : gcd_lcm_of(directed_rows[k].op_a,
                                                          directed_rows[k].op_b));
        end
        wait_all_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            random_operands(a, b);
            // items 600..899 go back to back
            send_item(a, b, idle_gap(n >= 600 && n < 900), gcd_lcm_of(a, b));
            if (n % 400 == 399) wait_all_results();
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
